[hw/rtl/ktc_pkg.sv]
// Package for the keystroke timing classifier: widths, the pass phrase,
// the sequencer states and the structs passed between the top level and the engine.
// No dependencies.
`timescale 1ns / 1ps

package ktc_pkg;

    localparam int KTC_PHRASE_LEN    = 10;
    localparam int KTC_TRAIN_REPEATS = 5;

    localparam int CHAR_W = 8;
    localparam int TICK_W = 16;
    localparam int POS_W  = 4;
    localparam int SQ_W   = 2 * TICK_W;
    localparam int DIST_W = 36;

    // Pass phrase ".tie5Ronal"; unused positions hold NUL.
    localparam logic [CHAR_W-1:0] PHRASE_CHARS [16] = '{
        8'h2E, 8'h74, 8'h69, 8'h65, 8'h35, 8'h52, 8'h6F, 8'h6E,
        8'h61, 8'h6C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    typedef enum logic {
        ST_IDLE,
        ST_SWEEP
    } ktc_state_t;

    typedef struct packed {
        logic start;
        logic train;
        logic sel_a;
        logic clear;
        logic divide;
    } sweep_cmd_t;

    typedef struct packed {
        logic              en;
        logic [POS_W-1:0]  addr;
        logic [TICK_W-1:0] data;
    } iv_wr_t;

    typedef struct packed {
        logic              done;
        logic [DIST_W-1:0] dist_a;
        logic [DIST_W-1:0] dist_b;
    } sweep_res_t;

endpackage

[hw/rtl/ktc_if.sv]
// Channel interfaces of the keystroke timing classifier: input items and result items.
// Depends on ktc_pkg for the field widths.
`timescale 1ns / 1ps

interface ktc_in_if
    import ktc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              func;
    logic [CHAR_W-1:0] key_char;
    logic              train_mode;
    logic              user_select;

    modport source (output valid, func, key_char, train_mode, user_select, input ready);
    modport sink   (input valid, func, key_char, train_mode, user_select, output ready);
endinterface

interface ktc_out_if
    import ktc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              status;
    logic              word_done;
    logic              decided;
    logic              class_b;
    logic [DIST_W-1:0] distance_a;
    logic [DIST_W-1:0] distance_b;

    modport source (output valid, status, word_done, decided, class_b, distance_a, distance_b,
                    input ready);
    modport sink   (input valid, status, word_done, decided, class_b, distance_a, distance_b,
                    output ready);
endinterface

[hw/rtl/ktc_engine.sv]
// Template engine: interval memory and packed A/B template memory, swept once per word.
// A four-stage pipeline reads, scales or accumulates, writes back and sums squared distances.
// Depends on ktc_pkg.
`timescale 1ns / 1ps

module ktc_engine
    import ktc_pkg::*;
#(
    parameter int NUM_IV        = KTC_PHRASE_LEN - 1,
    parameter int TRAIN_REPEATS = KTC_TRAIN_REPEATS
) (
    input  logic       clk,
    input  logic       rst_n,
    input  iv_wr_t     iv_wr,
    input  sweep_cmd_t cmd,
    output sweep_res_t res
);

    localparam int IDX_W   = (NUM_IV > 1) ? $clog2(NUM_IV) : 1;
    localparam int RECIP_W = 33;
    localparam int RECIP_SH = 32;
    localparam int PROD_W  = TICK_W + RECIP_W;
    // Reciprocal that makes (x * RECIP) >> 32 equal x / TRAIN_REPEATS for any 16-bit x.
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((64'h1_0000_0000 / TRAIN_REPEATS) + 1);

    logic [TICK_W-1:0]   iv_mem  [NUM_IV];
    logic [2*TICK_W-1:0] tpl_mem [NUM_IV];
    logic [NUM_IV-1:0]   tpl_vld_reg;

    // Captured word mode.
    logic train_m_reg, sel_m_reg, clr_m_reg, div_m_reg;

    // Issue stage.
    logic             iss_act_reg;
    logic [IDX_W-1:0] rd_idx_reg;

    // Stage 1: memory read data.
    logic                p1_vld_reg, p1_last_reg;
    logic [IDX_W-1:0]    p1_idx_reg;
    logic [TICK_W-1:0]   iv_rd_reg;
    logic [2*TICK_W-1:0] tpl_rd_reg;
    logic                tpl_ok_reg;

    // Stage 2: raw template values and scaled products.
    logic              p2_vld_reg, p2_last_reg;
    logic [IDX_W-1:0]  p2_idx_reg;
    logic [TICK_W-1:0] a2_reg, b2_reg, iv2_reg;
    logic [PROD_W-1:0] prod_a2_reg, prod_b2_reg;

    // Stage 3: squared differences.
    logic            p3_vld_reg, p3_last_reg;
    logic [SQ_W-1:0] sq_a3_reg, sq_b3_reg;

    logic [DIST_W-1:0] acc_a_reg, acc_b_reg;

    logic [TICK_W-1:0] tpl_a1, tpl_b1;
    logic [PROD_W-1:0] prod_a1, prod_b1;
    logic [TICK_W-1:0] base_a, base_b, sum_a, sum_b, new_a, new_b, diff_a, diff_b;
    logic              tpl_we;
    logic [DIST_W-1:0] sum_a_out, sum_b_out;

    assign tpl_a1  = tpl_ok_reg ? tpl_rd_reg[2*TICK_W-1:TICK_W] : '0;
    assign tpl_b1  = tpl_ok_reg ? tpl_rd_reg[TICK_W-1:0] : '0;
    assign prod_a1 = PROD_W'(tpl_a1) * PROD_W'(RECIP);
    assign prod_b1 = PROD_W'(tpl_b1) * PROD_W'(RECIP);

    always_comb
    begin
        base_a = clr_m_reg ? '0 : a2_reg;
        base_b = clr_m_reg ? '0 : b2_reg;
        sum_a  = base_a + iv2_reg;
        sum_b  = base_b + iv2_reg;
        if (train_m_reg)
        begin
            new_a = sel_m_reg ? sum_a : base_a;
            new_b = sel_m_reg ? base_b : sum_b;
        end
        else if (div_m_reg)
        begin
            new_a = prod_a2_reg[RECIP_SH +: TICK_W];
            new_b = prod_b2_reg[RECIP_SH +: TICK_W];
        end
        else
        begin
            new_a = a2_reg;
            new_b = b2_reg;
        end
        diff_a = (new_a >= iv2_reg) ? (new_a - iv2_reg) : (iv2_reg - new_a);
        diff_b = (new_b >= iv2_reg) ? (new_b - iv2_reg) : (iv2_reg - new_b);
    end

    assign tpl_we = p2_vld_reg && (train_m_reg || div_m_reg);

    assign sum_a_out = acc_a_reg + DIST_W'(sq_a3_reg);
    assign sum_b_out = acc_b_reg + DIST_W'(sq_b3_reg);

    assign res.done   = p3_vld_reg && p3_last_reg;
    assign res.dist_a = sum_a_out;
    assign res.dist_b = sum_b_out;

    // Memories and data path registers.
    always_ff @(posedge clk)
    begin
        if (iv_wr.en)
            iv_mem[iv_wr.addr[IDX_W-1:0]] <= iv_wr.data;
        if (tpl_we)
            tpl_mem[p2_idx_reg] <= {new_a, new_b};
        iv_rd_reg  <= iv_mem[rd_idx_reg];
        tpl_rd_reg <= tpl_mem[rd_idx_reg];
        tpl_ok_reg <= tpl_vld_reg[rd_idx_reg];
        p1_idx_reg <= rd_idx_reg;

        a2_reg      <= tpl_a1;
        b2_reg      <= tpl_b1;
        iv2_reg     <= iv_rd_reg;
        prod_a2_reg <= prod_a1;
        prod_b2_reg <= prod_b1;
        p2_idx_reg  <= p1_idx_reg;

        sq_a3_reg <= SQ_W'(diff_a) * SQ_W'(diff_a);
        sq_b3_reg <= SQ_W'(diff_b) * SQ_W'(diff_b);

        if (cmd.start)
        begin
            train_m_reg <= cmd.train;
            sel_m_reg   <= cmd.sel_a;
            clr_m_reg   <= cmd.clear;
            div_m_reg   <= cmd.divide;
        end
    end

    // Sweep control; template entries read as zero until first written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpl_vld_reg <= '0;
            iss_act_reg <= 1'b0;
            rd_idx_reg  <= '0;
            p1_vld_reg  <= 1'b0;
            p1_last_reg <= 1'b0;
            p2_vld_reg  <= 1'b0;
            p2_last_reg <= 1'b0;
            p3_vld_reg  <= 1'b0;
            p3_last_reg <= 1'b0;
            acc_a_reg   <= '0;
            acc_b_reg   <= '0;
        end
        else
        begin
            if (tpl_we)
                tpl_vld_reg[p2_idx_reg] <= 1'b1;

            if (cmd.start)
            begin
                iss_act_reg <= 1'b1;
                rd_idx_reg  <= '0;
            end
            else if (iss_act_reg)
            begin
                if (rd_idx_reg == IDX_W'(NUM_IV - 1))
                begin
                    iss_act_reg <= 1'b0;
                    rd_idx_reg  <= '0;
                end
                else
                    rd_idx_reg <= rd_idx_reg + 1'b1;
            end

            p1_vld_reg  <= iss_act_reg;
            p1_last_reg <= (rd_idx_reg == IDX_W'(NUM_IV - 1));
            p2_vld_reg  <= p1_vld_reg;
            p2_last_reg <= p1_last_reg;
            p3_vld_reg  <= p2_vld_reg;
            p3_last_reg <= p2_last_reg;

            if (p3_vld_reg)
            begin
                acc_a_reg <= p3_last_reg ? '0 : sum_a_out;
                acc_b_reg <= p3_last_reg ? '0 : sum_b_out;
            end
        end
    end

endmodule

[hw/rtl/keystroke_timing_classifier.sv]
// Keystroke timing classifier: top level with key matching, interval counter and result register.
// Depends on ktc_pkg, ktc_if and ktc_engine.
//
// Usage: req carries one item per handshake. func = 0 is a millisecond tick that only
// advances the 16-bit interval counter and gives no result. func = 1 is a keystroke that
// gives exactly one result item on rsp. A key that is not the next phrase character gives
// status = 1 and restarts the word.
// Response: a keystroke that does not finish the phrase is answered in the cycle after it
// is accepted. A finishing keystroke starts a sweep over the PHRASE_LEN-1 template entries:
// one read per cycle plus a four-stage pipeline; its result is registered when the sweep
// ends, with all reads going through the single read port of the template memory.
// Throughput: ticks and ordinary keys can be taken every cycle while the result register
// is free or being emptied; during a sweep no item is accepted.
// Reset: the counter, the key position and the templates clear; the next test word first
// divides the templates by TRAIN_REPEATS. When the receiver stalls, the result register
// holds and keystrokes and ticks wait until it is taken.
`timescale 1ns / 1ps

module keystroke_timing_classifier
    import ktc_pkg::*;
#(
    parameter int PHRASE_LEN    = KTC_PHRASE_LEN,
    parameter int TRAIN_REPEATS = KTC_TRAIN_REPEATS
) (
    input  logic           clk,
    input  logic           rst_n,
    ktc_in_if.sink         req,
    ktc_out_if.source      rsp
);

    ktc_state_t state_reg, state_next;

    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              pending_reg, pending_next;
    logic              word_train_reg, word_train_next;

    logic              out_vld_reg, out_vld_next;
    logic              out_status_reg, out_done_reg, out_decided_reg, out_class_reg;
    logic [DIST_W-1:0] out_dist_a_reg, out_dist_b_reg;

    logic       in_rdy, accept, hit, last_pos, word_end;
    iv_wr_t     iv_wr;
    sweep_cmd_t cmd;
    sweep_res_t res;

    ktc_engine #(
        .NUM_IV        (PHRASE_LEN - 1),
        .TRAIN_REPEATS (TRAIN_REPEATS)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .iv_wr (iv_wr),
        .cmd   (cmd),
        .res   (res)
    );

    assign hit      = (req.key_char == PHRASE_CHARS[pos_reg]);
    assign last_pos = (pos_reg == POS_W'(PHRASE_LEN - 1));

    always_comb
    begin
        state_next      = state_reg;
        tick_next       = tick_reg;
        pos_next        = pos_reg;
        pending_next    = pending_reg;
        word_train_next = word_train_reg;
        in_rdy          = 1'b0;
        word_end        = 1'b0;
        iv_wr.en        = 1'b0;
        iv_wr.addr      = pos_reg - 1'b1;
        iv_wr.data      = tick_reg;
        cmd.start       = 1'b0;
        cmd.train       = req.train_mode;
        cmd.sel_a       = req.user_select;
        cmd.clear       = req.train_mode && !pending_reg;
        cmd.divide      = !req.train_mode && pending_reg;

        case (state_reg)
            ST_IDLE:
            begin
                in_rdy = !out_vld_reg || rsp.ready;
                if (req.valid && in_rdy)
                begin
                    if (!req.func)
                        tick_next = tick_reg + 1'b1;
                    else if (hit)
                    begin
                        iv_wr.en  = (pos_reg != '0);
                        tick_next = '0;
                        if (last_pos)
                        begin
                            pos_next        = '0;
                            word_end        = 1'b1;
                            cmd.start       = 1'b1;
                            pending_next    = req.train_mode;
                            word_train_next = req.train_mode;
                            state_next      = ST_SWEEP;
                        end
                        else
                            pos_next = pos_reg + 1'b1;
                    end
                    else
                        pos_next = '0;
                end
            end
            ST_SWEEP:
            begin
                if (res.done)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign accept    = req.valid && in_rdy;
    assign req.ready = in_rdy;

    always_comb
    begin
        if (res.done)
            out_vld_next = 1'b1;
        else if (accept && req.func && !word_end)
            out_vld_next = 1'b1;
        else if (rsp.ready)
            out_vld_next = 1'b0;
        else
            out_vld_next = out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            tick_reg       <= '0;
            pos_reg        <= '0;
            pending_reg    <= 1'b1;
            word_train_reg <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tick_reg       <= tick_next;
            pos_reg        <= pos_next;
            pending_reg    <= pending_next;
            word_train_reg <= word_train_next;
            out_vld_reg    <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.done)
        begin
            out_status_reg  <= 1'b0;
            out_done_reg    <= 1'b1;
            out_decided_reg <= !word_train_reg;
            out_class_reg   <= !word_train_reg && !(res.dist_a < res.dist_b);
            out_dist_a_reg  <= word_train_reg ? '0 : res.dist_a;
            out_dist_b_reg  <= word_train_reg ? '0 : res.dist_b;
        end
        else if (accept && req.func && !word_end)
        begin
            out_status_reg  <= !hit;
            out_done_reg    <= 1'b0;
            out_decided_reg <= 1'b0;
            out_class_reg   <= 1'b0;
            out_dist_a_reg  <= '0;
            out_dist_b_reg  <= '0;
        end
    end

    assign rsp.valid      = out_vld_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.word_done  = out_done_reg;
    assign rsp.decided    = out_decided_reg;
    assign rsp.class_b    = out_class_reg;
    assign rsp.distance_a = out_dist_a_reg;
    assign rsp.distance_b = out_dist_b_reg;

`ifndef SYNTH
    // The engine only finishes a sweep that the sequencer is waiting for.
    a_done_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        res.done |-> state_reg == ST_SWEEP)
        else $error("sweep result outside a sweep");

    // The result register is empty for the whole sweep, so the word result cannot be lost.
    a_out_empty_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SWEEP |-> !out_vld_reg)
        else $error("result register busy during a sweep");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(PHRASE_LEN - 1))
        else $error("key position beyond the phrase");

    // An accepted tick advances the interval counter by exactly one.
    a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !req.func) |=> tick_reg == TICK_W'($past(tick_reg) + 1'b1))
        else $error("tick did not advance the counter");
`endif

endmodule
